### hw/rtl/tti_pkg.sv
`timescale 1ns / 1ps

package tti_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int VAL_W    = 20;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int CFG_W    = 7;
    localparam int SLOT_W   = 6;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_T2V  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_V2T  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SPAN  = 2'd2;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 20'sh7FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 20'sh80000;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_LAST,
        RD_NEXT
    } tti_rd_sel_t;

    typedef struct packed {
        logic                accept;
        logic                ram_we;
        tti_rd_sel_t         rd_sel;
        logic                load_prev;
        logic                load_diff;
        logic                load_prod;
        logic                div_start;
        logic                load_sum;
        logic                load_out;
        logic                out_use_res;
        logic [STATUS_W-1:0] out_status;
    } tti_ctl_t;

    typedef struct packed {
        logic is_load;
        logic is_conv;
        logic n_zero;
        logic n_one;
        logic out_of_range;
        logic found;
        logic at_last;
        logic span_zero;
        logic div_done;
    } tti_stat_t;

endpackage

### hw/rtl/tti_ram.sv
`timescale 1ns / 1ps

module tti_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/tti_divider.sv
`timescale 1ns / 1ps

// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module tti_divider #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 21
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] dividend,
    input  logic signed [DEN_W-1:0] divisor,
    output logic                    done,
    output logic signed [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            quo_next  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
            den_next  = divisor[DEN_W-1] ? DEN_W'(-divisor) : DEN_W'(divisor);
            neg_next  = dividend[NUM_W-1] ^ divisor[DEN_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);

endmodule

### hw/rtl/tti_datapath.sv
`timescale 1ns / 1ps

module tti_datapath import tti_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_W-1:0]           cfg_wr_data,
    input  logic [CMD_W-1:0]           cmd,
    input  logic [SLOT_W-1:0]          point_index,
    input  logic signed [VAL_W-1:0]    point_temperature,
    input  logic signed [VAL_W-1:0]    point_voltage,
    input  logic signed [VAL_W-1:0]    query_value,
    input  tti_ctl_t                   ctl,
    output tti_stat_t                  stat,
    output logic signed [VAL_W-1:0]    result_value,
    output logic [STATUS_W-1:0]        status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    logic [CFG_W-1:0]           points_used_reg;
    logic [CMD_W-1:0]           cmd_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [VAL_W-1:0]    pt_t_reg;
    logic signed [VAL_W-1:0]    pt_v_reg;
    logic signed [VAL_W-1:0]    q_reg;
    logic [AW-1:0]              idx_reg;
    logic signed [VAL_W-1:0]    prev_key_reg;
    logic signed [VAL_W-1:0]    prev_val_reg;
    logic signed [DIFF_W-1:0]   span_reg;
    logic signed [DIFF_W-1:0]   dv_reg;
    logic signed [DIFF_W-1:0]   dq_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [VAL_W-1:0]    res_reg;

    logic [NW-1:0]              n_w;
    logic [AW-1:0]              n_last;
    logic                       slot_ok;
    logic                       v2t;
    logic [AW-1:0]              rd_addr;
    logic [VAL_W-1:0]           t_rd;
    logic [VAL_W-1:0]           v_rd;
    logic signed [VAL_W-1:0]    key_rd;
    logic signed [VAL_W-1:0]    val_rd;
    logic                       div_done;
    logic signed [PROD_W-1:0]   quotient;
    logic signed [SUM_W-1:0]    sum_w;
    logic signed [VAL_W-1:0]    sat_w;

    assign n_w     = (int'(points_used_reg) > MAX_POINTS) ? NW'(MAX_POINTS)
                                                          : NW'(points_used_reg);
    assign n_last  = AW'(n_w - NW'(1));
    assign slot_ok = (int'(slot_reg) < MAX_POINTS);
    assign v2t     = (cmd_reg == CMD_V2T);

    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_LAST: rd_addr = n_last;
            RD_NEXT: rd_addr = idx_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    tti_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_temp_ram (
        .clk   (clk),
        .we    (ctl.ram_we && slot_ok),
        .waddr (AW'(slot_reg)),
        .wdata (pt_t_reg),
        .raddr (rd_addr),
        .rdata (t_rd)
    );

    tti_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_volt_ram (
        .clk   (clk),
        .we    (ctl.ram_we && slot_ok),
        .waddr (AW'(slot_reg)),
        .wdata (pt_v_reg),
        .raddr (rd_addr),
        .rdata (v_rd)
    );

    assign key_rd = v2t ? $signed(v_rd) : $signed(t_rd);
    assign val_rd = v2t ? $signed(t_rd) : $signed(v_rd);

    tti_divider #(
        .NUM_W (PROD_W),
        .DEN_W (DIFF_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign sum_w = SUM_W'(quotient) + SUM_W'(prev_val_reg);

    always_comb
    begin
        priority if (sum_w > SUM_W'(VAL_MAX))
        begin
            sat_w = VAL_MAX;
        end
        else if (sum_w < SUM_W'(VAL_MIN))
        begin
            sat_w = VAL_MIN;
        end
        else
        begin
            sat_w = sum_w[VAL_W-1:0];
        end
    end

    always_comb
    begin
        stat.is_load      = (cmd_reg == CMD_LOAD);
        stat.is_conv      = (cmd_reg == CMD_T2V) || (cmd_reg == CMD_V2T);
        stat.n_zero       = (n_w == '0);
        stat.n_one        = (n_w == NW'(1));
        stat.out_of_range = (q_reg < prev_key_reg) || (q_reg > key_rd);
        stat.found        = (q_reg <= key_rd);
        stat.at_last      = (idx_reg == n_last);
        stat.span_zero    = (span_reg == '0);
        stat.div_done     = div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_used_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            points_used_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= cmd;
            slot_reg <= point_index;
            pt_t_reg <= point_temperature;
            pt_v_reg <= point_voltage;
            q_reg    <= query_value;
            idx_reg  <= '0;
        end
        else if (ctl.rd_sel == RD_NEXT)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (ctl.load_prev)
        begin
            prev_key_reg <= key_rd;
            prev_val_reg <= val_rd;
        end
        if (ctl.load_diff)
        begin
            span_reg <= DIFF_W'(key_rd) - DIFF_W'(prev_key_reg);
            dv_reg   <= DIFF_W'(val_rd) - DIFF_W'(prev_val_reg);
            dq_reg   <= DIFF_W'(q_reg) - DIFF_W'(prev_key_reg);
        end
        if (ctl.load_prod)
        begin
            prod_reg <= PROD_W'(dv_reg * dq_reg);
        end
        if (ctl.load_sum)
        begin
            res_reg <= sat_w;
        end
        if (ctl.load_out)
        begin
            result_value <= ctl.out_use_res ? res_reg : '0;
            status       <= ctl.out_status;
        end
    end

endmodule

### hw/rtl/tti_ctrl.sv
`timescale 1ns / 1ps

module tti_ctrl import tti_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  tti_stat_t stat,
    output tti_ctl_t  ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_RD_LAST,
        S_CHECK,
        S_SCAN,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] st_code_reg, st_code_next;
    logic                use_res_reg, use_res_next;
    logic                out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        ctl             = '0;
        ctl.rd_sel      = RD_ZERO;
        ctl.out_use_res = use_res_reg;
        ctl.out_status  = st_code_reg;
        state_next      = state_reg;
        st_code_next    = st_code_reg;
        use_res_next    = use_res_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept   = 1'b1;
                    st_code_next = STATUS_OK;
                    use_res_next = 1'b0;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.is_load)
                begin
                    state_next = S_LOAD;
                end
                else if (stat.is_conv && stat.n_zero)
                begin
                    st_code_next = STATUS_SPAN;
                    state_next   = S_OUT;
                end
                else if (stat.is_conv)
                begin
                    ctl.rd_sel = RD_ZERO;
                    state_next = S_RD_LAST;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_LOAD:
            begin
                ctl.ram_we = 1'b1;
                state_next = S_OUT;
            end
            S_RD_LAST:
            begin
                ctl.load_prev = 1'b1;
                ctl.rd_sel    = RD_LAST;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (stat.out_of_range)
                begin
                    st_code_next = STATUS_RANGE;
                    state_next   = S_OUT;
                end
                else if (stat.n_one)
                begin
                    st_code_next = STATUS_SPAN;
                    state_next   = S_OUT;
                end
                else
                begin
                    ctl.rd_sel = RD_NEXT;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                priority if (stat.found)
                begin
                    ctl.load_diff = 1'b1;
                    state_next    = S_MUL;
                end
                else if (stat.at_last)
                begin
                    st_code_next = STATUS_SPAN;
                    state_next   = S_OUT;
                end
                else
                begin
                    ctl.load_prev = 1'b1;
                    ctl.rd_sel    = RD_NEXT;
                end
            end
            S_MUL:
            begin
                if (stat.span_zero)
                begin
                    st_code_next = STATUS_SPAN;
                    state_next   = S_OUT;
                end
                else
                begin
                    ctl.load_prod = 1'b1;
                    state_next    = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                ctl.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.load_sum = 1'b1;
                    use_res_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            st_code_reg   <= STATUS_OK;
            use_res_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            st_code_reg   <= st_code_next;
            use_res_reg   <= use_res_next;
        end
    end

endmodule

### hw/rtl/thermocouple_table_interpolator.sv
`timescale 1ns / 1ps

// Piecewise-linear thermocouple table: cmd 0 loads one (temperature, voltage)
// point, cmd 1 converts temperature (1/16 C) to microvolts, cmd 2 the reverse.
// Every transaction returns exactly one result (status 0 ok, 1 out of range,
// 2 empty table, no segment or zero span). Points must be loaded before
// points_used covers them. A conversion finds its segment by a linear scan
// (one table read per cycle from the point memory), then interpolates with
// the bit-serial divider. One transaction is in flight at a time; the next
// one is taken as soon as the result sits in the output register.
module thermocouple_table_interpolator import tti_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [SLOT_W-1:0]       point_index,
    input  logic signed [VAL_W-1:0] point_temperature,
    input  logic signed [VAL_W-1:0] point_voltage,
    input  logic signed [VAL_W-1:0] query_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] result_value,
    output logic [STATUS_W-1:0]     status
);

    tti_ctl_t  ctl;
    tti_stat_t stat;

    tti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    tti_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd               (cmd),
        .point_index       (point_index),
        .point_temperature (point_temperature),
        .point_voltage     (point_voltage),
        .query_value       (query_value),
        .ctl               (ctl),
        .stat              (stat),
        .result_value      (result_value),
        .status            (status)
    );

endmodule
